[sv/vertex_dedup_indexer_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the vertex dedup indexer
// Concurrent assertion wrappers clocked on clk_i; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef VERTEX_DEDUP_INDEXER_UNIT_ASSERT_SVH
`define VERTEX_DEDUP_INDEXER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside of reset.
`define VDI_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vdi assertion failed");
// Checked on every clock edge, reset included.
`define VDI_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("vdi assertion failed");
`else
`define VDI_ASSERT(label, prop)
`define VDI_ASSERT_ALWAYS(label, prop)
`endif

`endif

[sv/vdi_pkg.sv]
// ----------------------------------------------------------------------------
// vdi_pkg
// Field widths, key type and key canonicalization for the vertex dedup indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package vdi_pkg;

  localparam int unsigned POS_W       = 32;
  localparam int unsigned FIELD_IDX_W = 20;

  localparam logic [POS_W-1:0] NEG_ZERO = 32'h8000_0000;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
  } key_t;

  localparam int unsigned KEY_W = $bits(key_t);

  // Negative zero compares and stores as positive zero.
  function automatic pos_t canon_pos(input pos_t bits);
    return (bits == NEG_ZERO) ? '0 : bits;
  endfunction

  function automatic key_t make_key(input pos_t x, input pos_t y, input pos_t z);
    key_t k;
    k.x = canon_pos(x);
    k.y = canon_pos(y);
    k.z = canon_pos(z);
    return k;
  endfunction

endpackage

`default_nettype wire

[sv/vdi_if.sv]
// ----------------------------------------------------------------------------
// vdi_if
// Valid/ready channels for corner items in and index items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdi_in_if import vdi_pkg::*; ();
  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;
  pos_t pos_z;
  pos_t tex_u;
  pos_t tex_v;
  logic starts_rebuild;
  logic starts_object;
  logic ends_object;

  modport source (
    output valid, pos_x, pos_y, pos_z, tex_u, tex_v,
           starts_rebuild, starts_object, ends_object,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, tex_u, tex_v,
           starts_rebuild, starts_object, ends_object,
    output ready
  );
endinterface

interface vdi_out_if import vdi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_IDX_W-1:0] vertex_index;
  logic                   is_new;
  pos_t                   new_x;
  pos_t                   new_y;
  pos_t                   new_z;
  pos_t                   new_u;
  pos_t                   new_v;
  logic                   table_full;
  logic                   object_done;
  logic [FIELD_IDX_W-1:0] object_offset;
  logic [FIELD_IDX_W-1:0] object_count;

  modport source (
    output valid, vertex_index, is_new, new_x, new_y, new_z, new_u, new_v,
           table_full, object_done, object_offset, object_count,
    input  ready
  );
  modport sink (
    input  valid, vertex_index, is_new, new_x, new_y, new_z, new_u, new_v,
           table_full, object_done, object_offset, object_count,
    output ready
  );
endinterface

`default_nettype wire

[sv/vertex_dedup_indexer_unit.sv]
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_unit
// Welds triangle corners into indexed vertices with a per-object position table.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one triangle corner per item: position and texture bit
//   patterns plus the rebuild, object start and object end flags. out_o
//   returns exactly one item per corner: its vertex number, the new vertex
//   record when the position was not yet in the table, and the object's
//   offset and count on its last corner.
//   Each item is accepted, looked up and committed before the next one is
//   accepted. The table lives in one RAM with a single read port, compared
//   one slot per cycle, so each further slot compared lengthens the lookup,
//   and a new position is compared against every filled slot. After the
//   last slot is read, the lookup's done flag, the move to S_COMMIT and,
//   once it is free, the output register are loaded in turn.
//   Reset clears all counters and the table fill; the table RAM is not
//   cleared, as only slots below the fill count are ever compared.
//   When out_o's receiver stalls, the result waits in the output register
//   while the next corner is already accepted and looked up; that corner
//   then waits to commit until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_dedup_indexer_unit_assert.svh"

module vertex_dedup_indexer_unit import vdi_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned INDEX_BITS  = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vdi_in_if.sink    in_i,
  vdi_out_if.source out_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned FW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_COMMIT
  } state_e;

  state_e                state_q, state_d;
  logic [INDEX_BITS-1:0] nv_q, nv_d;
  logic [INDEX_BITS-1:0] it_q, it_d;
  logic [INDEX_BITS-1:0] os_q, os_d;
  logic [FW-1:0]         fill_q, fill_d;

  pos_t                  x_q, y_q, z_q, u_q, v_q;
  logic                  ends_q;
  logic                  found_q;
  logic [INDEX_BITS-1:0] hit_vnum_q;

  logic                   out_valid_q;
  logic [FIELD_IDX_W-1:0] out_vidx_q;
  logic                   out_new_q;
  pos_t                   out_x_q, out_y_q, out_z_q, out_u_q, out_v_q;
  logic                   out_full_q;
  logic                   out_done_q;
  logic [FIELD_IDX_W-1:0] out_offset_q;
  logic [FIELD_IDX_W-1:0] out_count_q;

  logic                  accept;
  logic                  commit;
  logic                  full;
  logic                  lk_done;
  logic                  lk_found;
  logic [INDEX_BITS-1:0] lk_vnum;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] vnum_sel;
  logic [INDEX_BITS-1:0] count_sel;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign commit     = (state_q == S_COMMIT) && (!out_valid_q || out_o.ready);
  assign full       = !found_q && (fill_q == FW'(TABLE_DEPTH));
  assign wr_en      = commit && !found_q && !full;
  assign vnum_sel   = found_q ? hit_vnum_q : nv_q;
  assign count_sel  = it_q + INDEX_BITS'(1) - os_q;

  // Rebuild and object start act before the corner is looked up.
  always_comb begin
    nv_d    = nv_q;
    it_d    = it_q;
    os_d    = os_q;
    fill_d  = fill_q;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.starts_rebuild) begin
            nv_d   = '0;
            it_d   = '0;
            os_d   = '0;
            fill_d = '0;
          end
          if (in_i.starts_object) begin
            fill_d = '0;
            os_d   = it_d;
          end
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (lk_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          it_d = it_q + INDEX_BITS'(1);
          if (!found_q) begin
            nv_d = nv_q + INDEX_BITS'(1);
            if (!full) begin
              fill_d = fill_q + FW'(1);
            end
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  vdi_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_lookup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .key_i    (make_key(in_i.pos_x, in_i.pos_y, in_i.pos_z)),
    .fill_i   (fill_d),
    .wr_en_i  (wr_en),
    .wr_addr_i(AW'(fill_q)),
    .wr_key_i (make_key(x_q, y_q, z_q)),
    .wr_vnum_i(nv_q),
    .done_o   (lk_done),
    .found_o  (lk_found),
    .vnum_o   (lk_vnum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nv_q        <= '0;
      it_q        <= '0;
      os_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nv_q    <= nv_d;
      it_q    <= it_d;
      os_q    <= os_d;
      fill_q  <= fill_d;
      if (accept) begin
        x_q    <= in_i.pos_x;
        y_q    <= in_i.pos_y;
        z_q    <= in_i.pos_z;
        u_q    <= in_i.tex_u;
        v_q    <= in_i.tex_v;
        ends_q <= in_i.ends_object;
      end
      if (state_q == S_LOOK && lk_done) begin
        found_q    <= lk_found;
        hit_vnum_q <= lk_vnum;
      end
      if (commit) begin
        out_valid_q  <= 1'b1;
        out_vidx_q   <= FIELD_IDX_W'(vnum_sel);
        out_new_q    <= !found_q;
        out_x_q      <= found_q ? '0 : x_q;
        out_y_q      <= found_q ? '0 : y_q;
        out_z_q      <= found_q ? '0 : z_q;
        out_u_q      <= found_q ? '0 : u_q;
        out_v_q      <= found_q ? '0 : v_q;
        out_full_q   <= full;
        out_done_q   <= ends_q;
        out_offset_q <= ends_q ? FIELD_IDX_W'(os_q) : '0;
        out_count_q  <= ends_q ? FIELD_IDX_W'(count_sel) : '0;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.vertex_index  = out_vidx_q;
  assign out_o.is_new        = out_new_q;
  assign out_o.new_x         = out_x_q;
  assign out_o.new_y         = out_y_q;
  assign out_o.new_z         = out_z_q;
  assign out_o.new_u         = out_u_q;
  assign out_o.new_v         = out_v_q;
  assign out_o.table_full    = out_full_q;
  assign out_o.object_done   = out_done_q;
  assign out_o.object_offset = out_offset_q;
  assign out_o.object_count  = out_count_q;

  `VDI_ASSERT(a_fill_bound, fill_q <= FW'(TABLE_DEPTH))
  `VDI_ASSERT(a_done_while_look, lk_done |-> state_q == S_LOOK)
  `VDI_ASSERT(a_new_bumps_vnum, commit && !found_q |=> nv_q == $past(nv_q) + INDEX_BITS'(1))
  `VDI_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_q && state_q == S_IDLE)

endmodule

`default_nettype wire

[sv/vdi_ram.sv]
// ----------------------------------------------------------------------------
// vdi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vdi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/vdi_lookup.sv]
// ----------------------------------------------------------------------------
// vdi_lookup
// Position table in RAM and the sequencer that scans its filled slots for a key.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_dedup_indexer_unit_assert.svh"

module vdi_lookup import vdi_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned INDEX_BITS  = 20,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned FW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  key_t                  key_i,
  input  logic [FW-1:0]         fill_i,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  key_t                  wr_key_i,
  input  logic [INDEX_BITS-1:0] wr_vnum_i,
  output logic                  done_o,
  output logic                  found_o,
  output logic [INDEX_BITS-1:0] vnum_o
);

  localparam int unsigned WORD_W = KEY_W + INDEX_BITS;

  typedef enum logic [0:0] {
    L_IDLE,
    L_SCAN
  } lstate_e;

  lstate_e               state_q, state_d;
  key_t                  key_q;
  logic [FW-1:0]         fill_q;
  logic [AW-1:0]         idx_q, idx_d;
  logic                  done_q, done_d;
  logic                  found_q, found_d;
  logic [INDEX_BITS-1:0] vnum_q, vnum_d;

  logic [AW-1:0]         rd_addr;
  logic [WORD_W-1:0]     rd_word;
  logic [WORD_W-1:0]     wr_word;
  key_t                  rd_key;
  logic [INDEX_BITS-1:0] rd_vnum;
  logic                  hit;
  logic                  last;

  assign wr_word         = {wr_key_i, wr_vnum_i};
  assign {rd_key, rd_vnum} = rd_word;

  vdi_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_word),
    .raddr_i(rd_addr),
    .rdata_o(rd_word)
  );

  // The read word in L_SCAN belongs to slot idx_q.
  assign hit  = (rd_key == key_q);
  assign last = ((FW'(idx_q) + FW'(1)) == fill_q);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    found_d = found_q;
    vnum_d  = vnum_q;
    rd_addr = '0;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          idx_d = '0;
          if (fill_i == '0) begin
            done_d  = 1'b1;
            found_d = 1'b0;
          end else begin
            state_d = L_SCAN;
          end
        end
      end
      L_SCAN: begin
        if (hit) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          vnum_d  = rd_vnum;
          state_d = L_IDLE;
        end else if (last) begin
          done_d  = 1'b1;
          found_d = 1'b0;
          state_d = L_IDLE;
        end else begin
          idx_d   = idx_q + AW'(1);
          rd_addr = idx_d;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      idx_q   <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      found_q <= found_d;
      vnum_q  <= vnum_d;
      if (state_q == L_IDLE && start_i) begin
        key_q  <= key_i;
        fill_q <= fill_i;
      end
    end
  end

  assign done_o  = done_q;
  assign found_o = found_q;
  assign vnum_o  = vnum_q;

  `VDI_ASSERT(a_scan_in_fill, state_q == L_SCAN |-> FW'(idx_q) < fill_q)
  `VDI_ASSERT(a_done_one_cycle, done_q |=> !done_q)
  `VDI_ASSERT(a_hit_needs_entries, done_q && found_q |-> fill_q != '0)
  `VDI_ASSERT(a_no_write_in_scan, wr_en_i |-> state_q == L_IDLE)

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vertex_dedup_indexer_unit. Corners are queued by a
// stimulus process and offered by a clocked driver. An in-bench predictor
// keeps its own position table and counters and computes each welded result.
// A clocked monitor compares every returned item field by field, while both
// sides of the handshake idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import vdi_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned INDEX_BITS   = 20;
  localparam int unsigned CYCLE_LIMIT  = 2_500_000;
  localparam int unsigned DRAIN_CYCLES = TABLE_DEPTH + 40;
  localparam int unsigned LONG_HOLD    = 600;

  typedef logic [INDEX_BITS-1:0] vnum_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
    pos_t u;
    pos_t v;
    logic rebuild;
    logic start;
    logic done;
  } corner_t;

  typedef struct packed {
    logic [FIELD_IDX_W-1:0] vertex_index;
    logic                   is_new;
    pos_t                   nx;
    pos_t                   ny;
    pos_t                   nz;
    pos_t                   nu;
    pos_t                   nv;
    logic                   table_full;
    logic                   object_done;
    logic [FIELD_IDX_W-1:0] offset;
    logic [FIELD_IDX_W-1:0] count;
  } weld_t;

  logic clk_i;
  logic rst_ni;

  vdi_in_if  corner_ch ();
  vdi_out_if weld_ch ();

  vertex_dedup_indexer_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (corner_ch),
    .out_o (weld_ch)
  );

  // Predictor state: the position table of the current object and the counters.
  key_t        slot_key  [TABLE_DEPTH];
  vnum_t       slot_vnum [TABLE_DEPTH];
  int unsigned slots_used   = 0;
  vnum_t       vnum_next    = '0;
  vnum_t       index_total  = '0;
  vnum_t       object_start = '0;

  corner_t     corner_q[$];
  corner_t     offered;
  weld_t       welded_q[$];
  int unsigned items_queued  = 0;
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 79;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;

  function automatic pos_t fold_zero(input pos_t b);
    return (b == NEG_ZERO) ? '0 : b;
  endfunction

  function automatic pos_t swap_zero_sign(input pos_t b);
    if (b == '0) return NEG_ZERO;
    if (b == NEG_ZERO) return '0;
    return b;
  endfunction

  function automatic weld_t weld_corner(input corner_t c);
    weld_t r;
    key_t  k;
    bit    hit;
    vnum_t vn;
    r     = '0;
    k.x   = fold_zero(c.x);
    k.y   = fold_zero(c.y);
    k.z   = fold_zero(c.z);
    hit   = 1'b0;
    vn    = '0;
    if (c.rebuild) begin
      vnum_next    = '0;
      index_total  = '0;
      object_start = '0;
      slots_used   = 0;
    end
    if (c.start) begin
      slots_used   = 0;
      object_start = index_total;
    end
    for (int i = 0; i < slots_used; i++) begin
      if (!hit && slot_key[i] == k) begin
        hit = 1'b1;
        vn  = slot_vnum[i];
      end
    end
    if (!hit) begin
      vn = vnum_next;
      if (slots_used < TABLE_DEPTH) begin
        slot_key[slots_used]  = k;
        slot_vnum[slots_used] = vn;
        slots_used++;
      end else begin
        r.table_full = 1'b1;
      end
      vnum_next = vnum_next + 1'b1;
      r.is_new  = 1'b1;
      r.nx      = c.x;
      r.ny      = c.y;
      r.nz      = c.z;
      r.nu      = c.u;
      r.nv      = c.v;
    end
    index_total    = index_total + 1'b1;
    r.vertex_index = vn;
    if (c.done) begin
      r.object_done = 1'b1;
      r.offset      = object_start;
      r.count       = index_total - object_start;
    end
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got, inout bit bad);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch on result %0d, %s: expected %h, got %h",
                 results_seen, fname, want, got);
      bad = 1'b1;
    end
  endtask

  // Driver: holds an item until it is accepted, then may offer the next one
  // on the same edge so that valid stays high.
  always @(posedge clk_i) begin : drive
    logic offer;
    if (!rst_ni) begin
      corner_ch.valid <= 1'b0;
    end else begin
      offer = corner_ch.valid;
      if (corner_ch.valid && corner_ch.ready) begin
        welded_q = {welded_q, weld_corner(offered)};
        offer = 1'b0;
      end
      if (!offer && corner_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered                  = corner_q.pop_front();
        corner_ch.pos_x          <= offered.x;
        corner_ch.pos_y          <= offered.y;
        corner_ch.pos_z          <= offered.z;
        corner_ch.tex_u          <= offered.u;
        corner_ch.tex_v          <= offered.v;
        corner_ch.starts_rebuild <= offered.rebuild;
        corner_ch.starts_object  <= offered.start;
        corner_ch.ends_object    <= offered.done;
        offer = 1'b1;
      end
      corner_ch.valid <= offer;
    end
  end

  always @(posedge clk_i) begin : collect
    weld_t want;
    bit    bad;
    if (!rst_ni) begin
      weld_ch.ready <= 1'b0;
    end else begin
      if (weld_ch.valid && weld_ch.ready) begin
        results_seen++;
        if (welded_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result item %0d, vertex_index %h",
                     results_seen, weld_ch.vertex_index);
          mismatches++;
        end else begin
          want = welded_q.pop_front();
          bad  = 1'b0;
          check_field("vertex_index", 32'(want.vertex_index), 32'(weld_ch.vertex_index),
                      bad);
          check_field("is_new", 32'(want.is_new), 32'(weld_ch.is_new), bad);
          check_field("new_x", want.nx, weld_ch.new_x, bad);
          check_field("new_y", want.ny, weld_ch.new_y, bad);
          check_field("new_z", want.nz, weld_ch.new_z, bad);
          check_field("new_u", want.nu, weld_ch.new_u, bad);
          check_field("new_v", want.nv, weld_ch.new_v, bad);
          check_field("table_full", 32'(want.table_full), 32'(weld_ch.table_full), bad);
          check_field("object_done", 32'(want.object_done), 32'(weld_ch.object_done),
                      bad);
          check_field("object_offset", 32'(want.offset), 32'(weld_ch.object_offset),
                      bad);
          check_field("object_count", 32'(want.count), 32'(weld_ch.object_count), bad);
          if (bad) mismatches++;
        end
        // Long hold-offs let the block fill up and back-pressure the input.
        if (results_seen == 150 || results_seen == 900) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        weld_ch.ready <= 1'b0;
      end else begin
        weld_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic push_corner(input pos_t x, input pos_t y, input pos_t z,
                             input pos_t u, input pos_t v, input logic rebuild,
                             input logic start, input logic done);
    corner_t c;
    c = '{x: x, y: y, z: z, u: u, v: v, rebuild: rebuild, start: start, done: done};
    corner_q = {corner_q, c};
    items_queued++;
  endtask

  // Positions that are unique by y, so the table can be driven past full.
  task automatic push_filler(input int unsigned i, input logic start, input logic done);
    push_corner(32'hA5A5_0000 ^ i, i, i * 32'h9E37_79B9, $urandom, $urandom,
                1'b0, start, done);
  endtask

  function automatic pos_t rand_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return NEG_ZERO;
      2:       return 32'h7FC0_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (corner_q.size() != 0 || corner_ch.valid || welded_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Mostly well-formed objects drawn from a small pool of positions, so that
  // positions repeat; a few objects lose their start or end flag, and some
  // items are pure noise.
  task automatic queue_objects(input int unsigned n);
    pos_t        px [16];
    pos_t        py [16];
    pos_t        pz [16];
    int unsigned base;
    int unsigned corners;
    int unsigned pool;
    int unsigned pick;
    bit          keep_start;
    bit          keep_end;
    bit          rebuild;
    base = items_queued;
    while (items_queued - base < n) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(1, 3))
          push_corner($urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(3) == 0, 1'($urandom_range(1)),
                      1'($urandom_range(1)));
      end else begin
        pool = $urandom_range(1, 12);
        for (int i = 0; i < pool; i++) begin
          px[i] = rand_coord();
          py[i] = rand_coord();
          pz[i] = rand_coord();
          if (i != 0 && $urandom_range(2) == 0) begin
            // Near miss on one coordinate, or the same key with flipped zeros.
            px[i] = px[i-1];
            py[i] = py[i-1];
            pz[i] = pz[i-1];
            case ($urandom_range(3))
              0: px[i] = rand_coord();
              1: py[i] = rand_coord();
              2: pz[i] = rand_coord();
              default: begin
                px[i] = swap_zero_sign(px[i]);
                py[i] = swap_zero_sign(py[i]);
                pz[i] = swap_zero_sign(pz[i]);
              end
            endcase
          end
        end
        corners    = 3 * $urandom_range(1, 10);
        keep_start = ($urandom_range(9) != 0);
        keep_end   = ($urandom_range(9) != 0);
        rebuild    = keep_start && ($urandom_range(9) == 0);
        for (int c = 0; c < corners; c++) begin
          pick = $urandom_range(pool - 1);
          push_corner(px[pick], py[pick], pz[pick], $urandom, $urandom,
                      c == 0 && rebuild, c == 0 && keep_start,
                      c == corners - 1 && keep_end);
        end
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Signed zeros, NaN patterns, keys differing in one coordinate.
    push_corner('0, '0, '0, '0, '0, 1'b1, 1'b1, 1'b0);
    push_corner(NEG_ZERO, NEG_ZERO, NEG_ZERO, '1, '1, 1'b0, 1'b0, 1'b0);
    push_corner('0, NEG_ZERO, '0, 32'h3F80_0000, '0, 1'b0, 1'b0, 1'b0);
    push_corner('1, '1, '1, '1, '1, 1'b0, 1'b0, 1'b0);
    push_corner('1, '1, '1, '0, '0, 1'b0, 1'b0, 1'b0);
    push_corner(32'h7FC0_0000, 32'd1, 32'd2, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
    push_corner(32'h7FC0_0001, 32'd1, 32'd2, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
    push_corner('1, '1, 32'hFFFF_FFFE, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
    push_corner('0, '0, '0, $urandom, $urandom, 1'b0, 1'b0, 1'b1);
    // No object start after an end: the table carries on.
    push_corner('0, '0, '0, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
    push_corner(32'h7FC0_0000, 32'd1, 32'd2, $urandom, $urandom, 1'b0, 1'b0, 1'b1);
    // Rebuild alone also empties the table.
    push_corner(NEG_ZERO, '0, '0, $urandom, $urandom, 1'b1, 1'b0, 1'b0);
    push_corner('0, '0, '0, $urandom, $urandom, 1'b0, 1'b1, 1'b0);
    push_corner(32'h8000_0001, NEG_ZERO, 32'h7F80_0000, '1, '0, 1'b0, 1'b1, 1'b1);
    push_corner(32'hFF80_0000, 32'd1, 32'h8000_0001, '0, '1, 1'b1, 1'b1, 1'b1);
    push_corner(NEG_ZERO, '0, NEG_ZERO, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
    push_corner('0, '0, '0, $urandom, $urandom, 1'b0, 1'b0, 1'b1);
    push_corner(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, $urandom, $urandom,
                1'b0, 1'b1, 1'b0);
    push_corner(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0E, $urandom, $urandom,
                1'b0, 1'b0, 1'b0);
    push_corner(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, $urandom, $urandom,
                1'b0, 1'b0, 1'b1);

    queue_objects(480);
    wait_drained();

    send_idle_pct = 79;
    recv_idle_pct = 38;
    queue_objects(480);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // One object with more distinct positions than the table holds; a
    // position that did not fit comes back new, a stored one is still found.
    for (int i = 0; i < TABLE_DEPTH + 6; i++) push_filler(i, i == 0, 1'b0);
    push_filler(TABLE_DEPTH + 2, 1'b0, 1'b0);
    push_filler(5, 1'b0, 1'b0);
    push_filler(TABLE_DEPTH - 1, 1'b0, 1'b1);
    queue_objects(450);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && welded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/vdi_pkg.sv
sv/vdi_if.sv
sv/vdi_ram.sv
sv/vdi_lookup.sv
sv/vertex_dedup_indexer_unit.sv
sim/tb.sv
